### rtl/mae_pkg.sv
package mae_pkg;

	localparam int MAX_DIM   = 8;
	localparam int ELEM_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int DIM_W     = 4;
	localparam int PROD_W    = 2 * ELEM_W;
	localparam int TERM_W    = PROD_W - FRAC_BITS;
	localparam int ACC_W     = TERM_W + IDX_W;

	localparam logic [1:0] ACT_WR_A = 2'd0;
	localparam logic [1:0] ACT_WR_B = 2'd1;
	localparam logic [1:0] ACT_RUN  = 2'd2;

	localparam logic [2:0] OP_ADD   = 3'd0;
	localparam logic [2:0] OP_SUB   = 3'd1;
	localparam logic [2:0] OP_MUL   = 3'd2;
	localparam logic [2:0] OP_SCALE = 3'd3;
	localparam logic [2:0] OP_POW   = 3'd4;

	localparam logic [2:0] REG_OP     = 3'd0;
	localparam logic [2:0] REG_A_ROWS = 3'd1;
	localparam logic [2:0] REG_A_COLS = 3'd2;
	localparam logic [2:0] REG_B_ROWS = 3'd3;
	localparam logic [2:0] REG_B_COLS = 3'd4;
	localparam logic [2:0] REG_EXP    = 3'd5;
	localparam logic [2:0] REG_SCALE  = 3'd6;

	typedef logic [MAX_DIM-1:0][ELEM_W-1:0] row_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CALC, ST_WAIT, ST_DRAIN, ST_EMIT
	} st_t;

	typedef enum logic [2:0] {
		PH_ADD, PH_SUB, PH_COPY, PH_SCALE, PH_MUL, PH_POW
	} ph_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic mul;
		logic sub;
		logic load;
		logic shift;
	} cell_ctl_t;

	function automatic logic [DIM_W-1:0] dim_clip(input logic [DIM_W-1:0] r);
		logic [DIM_W-1:0] v;
		v = r;
		if (r == '0)
			v = DIM_W'(1);
		else if (r > DIM_W'(MAX_DIM))
			v = DIM_W'(MAX_DIM);
		return v;
	endfunction

	function automatic logic [ELEM_W-1:0] sat_elem(input logic [ACC_W-1:0] v);
		logic [ELEM_W-1:0] r;
		if (v[ACC_W-1:ELEM_W-1] == '0 || v[ACC_W-1:ELEM_W-1] == '1)
			r = v[ELEM_W-1:0];
		else if (v[ACC_W-1])
			r = {1'b1, {(ELEM_W-1){1'b0}}};
		else
			r = {1'b0, {(ELEM_W-1){1'b1}}};
		return r;
	endfunction

endpackage

### rtl/mae_if.sv
interface mae_in_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    action;
	logic [mae_pkg::IDX_W-1:0]     row_index;
	logic [mae_pkg::IDX_W-1:0]     col_index;
	logic signed [mae_pkg::ELEM_W-1:0] elem_value;

	modport source (output valid, action, row_index, col_index, elem_value, input ready);
	modport sink   (input valid, action, row_index, col_index, elem_value, output ready);
endinterface

interface mae_out_if;
	logic                          valid;
	logic                          ready;
	logic [mae_pkg::IDX_W-1:0]     out_row;
	logic [mae_pkg::IDX_W-1:0]     out_col;
	logic signed [mae_pkg::ELEM_W-1:0] out_value;
	logic                          last_elem;
	logic                          status;

	modport source (output valid, out_row, out_col, out_value, last_elem, status, input ready);
	modport sink   (input valid, out_row, out_col, out_value, last_elem, status, output ready);
endinterface

### rtl/mae_store.sv
module mae_store (
	input  logic                          clk,
	input  logic                          we,
	input  logic [mae_pkg::IDX_W-1:0]     wrow,
	input  logic [mae_pkg::IDX_W-1:0]     wcol,
	input  logic [mae_pkg::ELEM_W-1:0]    wdata,
	input  logic [mae_pkg::IDX_W-1:0]     rrow,
	output mae_pkg::row_t                 rdata
);

	mae_pkg::row_t mem [mae_pkg::MAX_DIM];

	always_ff @(posedge clk) begin
		if (we)
			mem[wrow][wcol] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[rrow];
	end

endmodule

### rtl/mae_cell.sv
module mae_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mae_pkg::cell_ctl_t            ctl,
	input  logic signed [mae_pkg::ELEM_W-1:0] x,
	input  logic signed [mae_pkg::ELEM_W-1:0] y,
	input  logic [mae_pkg::ELEM_W-1:0]    nbr_in,
	output logic [mae_pkg::ELEM_W-1:0]    sh_out
);

	logic signed [mae_pkg::PROD_W-1:0]   prod;
	logic signed [mae_pkg::ELEM_W:0]     sum;
	logic [mae_pkg::TERM_W-1:0]          term_s1;
	logic                                val_s1, first_s1;
	logic [mae_pkg::ACC_W-1:0]           acc_q;
	logic [mae_pkg::ELEM_W-1:0]          sh_q;

	assign prod = x * y;
	assign sum  = ctl.sub ? ({x[mae_pkg::ELEM_W-1], x} - {y[mae_pkg::ELEM_W-1], y})
	                      : ({x[mae_pkg::ELEM_W-1], x} + {y[mae_pkg::ELEM_W-1], y});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_s1   <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			val_s1   <= ctl.valid;
			first_s1 <= ctl.first;
		end
	end

	// product keeps its high bits: floor of the fraction drop
	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			if (ctl.mul)
				term_s1 <= prod[mae_pkg::PROD_W-1:mae_pkg::FRAC_BITS];
			else
				term_s1 <= {{(mae_pkg::TERM_W-mae_pkg::ELEM_W-1){sum[mae_pkg::ELEM_W]}}, sum};
		end
	end

	always_ff @(posedge clk) begin
		if (val_s1)
			acc_q <= (first_s1 ? '0 : acc_q)
			       + {{(mae_pkg::ACC_W-mae_pkg::TERM_W){term_s1[mae_pkg::TERM_W-1]}}, term_s1};
	end

	always_ff @(posedge clk) begin
		if (ctl.load)
			sh_q <= mae_pkg::sat_elem(acc_q);
		else if (ctl.shift)
			sh_q <= nbr_in;
	end

	assign sh_out = sh_q;

endmodule

### rtl/matrix_arith_engine_unit.sv
// Channel  Dir  Handshake     Word
// in_ch    in   valid/ready   action, row_index, col_index, elem_value
// out_ch   out  valid/ready   out_row, out_col, out_value, last_elem, status
// cfg      in   cfg_we only   cfg_index, cfg_data (no read-back)
//
// Element writes are taken one per cycle while idle. A run word holds in_ch.ready
// low until the whole result is in the output register path.
// Per result row the cell chain issues its steps (the inner dimension for
// multiply/power passes, 1 otherwise), waits out the store read plus the two cell
// stages, then shifts the row out of the chain into the result store. Power runs
// one copy pass plus (exponent-1) multiply passes.
// Emission: one word per cycle while out_ch is not stalled, after a store read per row.
// arst_n clears control state only; the stores are undefined until written.
module matrix_arith_engine_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	mae_in_if.sink                        in_ch,
	mae_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [2:0]                    cfg_index,
	input  logic [mae_pkg::ELEM_W-1:0]    cfg_data
);

	localparam int N = mae_pkg::MAX_DIM;
	localparam int IW = mae_pkg::IDX_W;
	localparam int EW = mae_pkg::ELEM_W;
	localparam int DW = mae_pkg::DIM_W;

	// configuration registers
	logic [2:0]    op_q;
	logic [DW-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
	logic [7:0]    exp_q;
	logic [EW-1:0] scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q     <= mae_pkg::OP_ADD;
			a_rows_q <= DW'(1);
			a_cols_q <= DW'(1);
			b_rows_q <= DW'(1);
			b_cols_q <= DW'(1);
			exp_q    <= 8'd1;
			scale_q  <= EW'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				mae_pkg::REG_OP:     op_q     <= cfg_data[2:0];
				mae_pkg::REG_A_ROWS: a_rows_q <= cfg_data[DW-1:0];
				mae_pkg::REG_A_COLS: a_cols_q <= cfg_data[DW-1:0];
				mae_pkg::REG_B_ROWS: b_rows_q <= cfg_data[DW-1:0];
				mae_pkg::REG_B_COLS: b_cols_q <= cfg_data[DW-1:0];
				mae_pkg::REG_EXP:    exp_q    <= cfg_data[7:0];
				mae_pkg::REG_SCALE:  scale_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [DW-1:0] ar, ac, br, bc;
	logic [IW-1:0] ar_m1, ac_m1;
	assign ar = mae_pkg::dim_clip(a_rows_q);
	assign ac = mae_pkg::dim_clip(a_cols_q);
	assign br = mae_pkg::dim_clip(b_rows_q);
	assign bc = mae_pkg::dim_clip(b_cols_q);
	assign ar_m1 = IW'(ar - DW'(1));
	assign ac_m1 = IW'(ac - DW'(1));

	// control state
	mae_pkg::st_t  state_q, state_d;
	mae_pkg::ph_t  phase_q, phase_d;
	logic          status_q, status_d, src_r_q, src_r_d, prime_q, prime_d;
	logic [DW-1:0] rc_q, rc_d;
	logic [IW-1:0] i_q, i_d, k_q, k_d, d_q, d_d, ei_q, ei_d, ej_q, ej_d;
	logic [1:0]    w_q, w_d;
	logic [7:0]    iter_q, iter_d;
	logic [IW-1:0] rc_m1;
	assign rc_m1 = IW'(rc_q - DW'(1));

	// issue word for the cell row, registered alongside the store read
	typedef struct packed {
		logic          valid;
		logic          first;
		logic [IW-1:0] k;
	} issue_t;
	issue_t issue_d, issue_s0;

	logic          in_acc, out_load, ld_last;
	logic          cell_load, cell_shift;
	logic [IW-1:0] a_ra, b_ra, r_ra;
	mae_pkg::row_t a_rd, b_rd, r_rd;
	logic [EW-1:0] chain [N+1];

	assign in_ch.ready = (state_q == mae_pkg::ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;

	logic pow_pass, steps_last;
	assign pow_pass   = (phase_q == mae_pkg::PH_MUL) || (phase_q == mae_pkg::PH_POW);
	assign steps_last = pow_pass ? (k_q == ac_m1) : 1'b1;

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		status_d  = status_q;
		src_r_d   = src_r_q;
		prime_d   = prime_q;
		rc_d      = rc_q;
		i_d       = i_q;
		k_d       = k_q;
		d_d       = d_q;
		w_d       = w_q;
		iter_d    = iter_q;
		ei_d      = ei_q;
		ej_d      = ej_q;
		issue_d   = '0;
		cell_load = 1'b0;
		cell_shift = 1'b0;
		out_load  = 1'b0;
		ld_last   = 1'b0;
		case (state_q)
			mae_pkg::ST_IDLE: begin
				if (in_acc && in_ch.action == mae_pkg::ACT_RUN) begin
					// default plan: A passes unchanged
					status_d = 1'b1;
					src_r_d  = 1'b0;
					rc_d     = ac;
					state_d  = mae_pkg::ST_EMIT;
					prime_d  = 1'b1;
					ei_d     = '0;
					ej_d     = '0;
					i_d      = '0;
					k_d      = '0;
					case (op_q)
						mae_pkg::OP_ADD, mae_pkg::OP_SUB: begin
							if (ar == br && ac == bc) begin
								status_d = 1'b0;
								phase_d  = (op_q == mae_pkg::OP_ADD) ? mae_pkg::PH_ADD
								                                     : mae_pkg::PH_SUB;
								state_d  = mae_pkg::ST_CALC;
							end
						end
						mae_pkg::OP_MUL: begin
							if (ac == br) begin
								status_d = 1'b0;
								phase_d  = mae_pkg::PH_MUL;
								rc_d     = bc;
								state_d  = mae_pkg::ST_CALC;
							end
						end
						mae_pkg::OP_SCALE: begin
							status_d = 1'b0;
							phase_d  = mae_pkg::PH_SCALE;
							state_d  = mae_pkg::ST_CALC;
						end
						mae_pkg::OP_POW: begin
							if (ar == ac) begin
								status_d = 1'b0;
								if (exp_q > 8'd1) begin
									phase_d = mae_pkg::PH_COPY;
									state_d = mae_pkg::ST_CALC;
								end
							end
						end
						default: ;
					endcase
				end
			end
			mae_pkg::ST_CALC: begin
				issue_d.valid = 1'b1;
				issue_d.first = (k_q == '0);
				issue_d.k     = k_q;
				if (steps_last) begin
					state_d = mae_pkg::ST_WAIT;
					w_d     = '0;
				end else begin
					k_d = k_q + IW'(1);
				end
			end
			mae_pkg::ST_WAIT: begin
				w_d = w_q + 2'd1;
				if (w_q == 2'd2) begin
					cell_load = 1'b1;
					state_d   = mae_pkg::ST_DRAIN;
					d_d       = '0;
				end
			end
			mae_pkg::ST_DRAIN: begin
				cell_shift = 1'b1;
				d_d        = d_q + IW'(1);
				if (d_q == rc_m1) begin
					k_d     = '0;
					state_d = mae_pkg::ST_CALC;
					if (i_q == ar_m1) begin
						i_d = '0;
						if (phase_q == mae_pkg::PH_COPY) begin
							phase_d = mae_pkg::PH_POW;
							iter_d  = 8'd1;
						end else if (phase_q == mae_pkg::PH_POW
						             && iter_q != exp_q - 8'd1) begin
							iter_d = iter_q + 8'd1;
						end else begin
							state_d = mae_pkg::ST_EMIT;
							src_r_d = 1'b1;
							prime_d = 1'b1;
							ei_d    = '0;
							ej_d    = '0;
						end
					end else begin
						i_d = i_q + IW'(1);
					end
				end
			end
			mae_pkg::ST_EMIT: begin
				if (prime_q) begin
					prime_d = 1'b0;
				end else if (!out_ch.valid || out_ch.ready) begin
					out_load = 1'b1;
					if (ej_q == rc_m1) begin
						ej_d = '0;
						if (ei_q == ar_m1) begin
							ld_last = 1'b1;
							state_d = mae_pkg::ST_IDLE;
						end else begin
							ei_d    = ei_q + IW'(1);
							prime_d = 1'b1;
						end
					end else begin
						ej_d = ej_q + IW'(1);
					end
				end
			end
			default: state_d = mae_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mae_pkg::ST_IDLE;
			phase_q  <= mae_pkg::PH_ADD;
			status_q <= 1'b0;
			src_r_q  <= 1'b0;
			prime_q  <= 1'b0;
			rc_q     <= DW'(1);
			i_q      <= '0;
			k_q      <= '0;
			d_q      <= '0;
			w_q      <= '0;
			iter_q   <= '0;
			ei_q     <= '0;
			ej_q     <= '0;
			issue_s0 <= '0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			status_q <= status_d;
			src_r_q  <= src_r_d;
			prime_q  <= prime_d;
			rc_q     <= rc_d;
			i_q      <= i_d;
			k_q      <= k_d;
			d_q      <= d_d;
			w_q      <= w_d;
			iter_q   <= iter_d;
			ei_q     <= ei_d;
			ej_q     <= ej_d;
			issue_s0 <= issue_d;
		end
	end

	// store read rows: A serves as multiplicand column source in power passes
	always_comb begin
		a_ra = i_q;
		b_ra = i_q;
		r_ra = i_q;
		if (state_q == mae_pkg::ST_EMIT) begin
			a_ra = ei_q;
			r_ra = ei_q;
		end else if (phase_q == mae_pkg::PH_POW) begin
			a_ra = k_q;
		end else if (phase_q == mae_pkg::PH_MUL) begin
			b_ra = k_q;
		end
	end

	mae_store u_store_a (
		.clk   (clk),
		.we    (in_acc && in_ch.action == mae_pkg::ACT_WR_A),
		.wrow  (in_ch.row_index),
		.wcol  (in_ch.col_index),
		.wdata (in_ch.elem_value),
		.rrow  (a_ra),
		.rdata (a_rd)
	);

	mae_store u_store_b (
		.clk   (clk),
		.we    (in_acc && in_ch.action == mae_pkg::ACT_WR_B),
		.wrow  (in_ch.row_index),
		.wcol  (in_ch.col_index),
		.wdata (in_ch.elem_value),
		.rrow  (b_ra),
		.rdata (b_rd)
	);

	// result store takes the chain head one column per drain cycle
	mae_store u_store_r (
		.clk   (clk),
		.we    (state_q == mae_pkg::ST_DRAIN),
		.wrow  (i_q),
		.wcol  (d_q),
		.wdata (chain[0]),
		.rrow  (r_ra),
		.rdata (r_rd)
	);

	// cell chain: lane j accumulates result column j, then shifts toward lane 0
	assign chain[N] = '0;

	for (genvar j = 0; j < N; j++) begin : g_cell
		logic [EW-1:0]      lx, ly;
		mae_pkg::cell_ctl_t cc;

		always_comb begin
			lx = a_rd[j];
			ly = b_rd[j];
			case (phase_q)
				mae_pkg::PH_ADD, mae_pkg::PH_SUB: ;
				mae_pkg::PH_COPY:  ly = '0;
				mae_pkg::PH_SCALE: ly = scale_q;
				mae_pkg::PH_MUL:   lx = a_rd[issue_s0.k];
				mae_pkg::PH_POW: begin
					lx = r_rd[issue_s0.k];
					ly = a_rd[j];
				end
				default: ;
			endcase
			cc.valid = issue_s0.valid;
			cc.first = issue_s0.first;
			cc.mul   = (phase_q == mae_pkg::PH_SCALE) || pow_pass;
			cc.sub   = (phase_q == mae_pkg::PH_SUB);
			cc.load  = cell_load;
			cc.shift = cell_shift;
		end

		mae_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cc),
			.x      (lx),
			.y      (ly),
			.nbr_in (chain[j+1]),
			.sh_out (chain[j])
		);
	end

	// output register
	logic          out_v_q;
	logic [IW-1:0] o_row_q, o_col_q;
	logic [EW-1:0] o_val_q;
	logic          o_last_q, o_stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (out_load)
			out_v_q <= 1'b1;
		else if (out_ch.ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_row_q  <= ei_q;
			o_col_q  <= ej_q;
			o_val_q  <= src_r_q ? r_rd[ej_q] : a_rd[ej_q];
			o_last_q <= ld_last;
			o_stat_q <= status_q;
		end
	end

	assign out_ch.valid     = out_v_q;
	assign out_ch.out_row   = o_row_q;
	assign out_ch.out_col   = o_col_q;
	assign out_ch.out_value = o_val_q;
	assign out_ch.last_elem = o_last_q;
	assign out_ch.status    = o_stat_q;

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ld_last |=> state_q == mae_pkg::ST_IDLE)
		else $error("last word did not end the run");

	a_issue_in_calc: assert property (@(posedge clk) disable iff (!arst_n)
		issue_s0.valid |-> (state_q == mae_pkg::ST_CALC || state_q == mae_pkg::ST_WAIT))
		else $error("cell step outside compute");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.out_row <= ar_m1)
		else $error("emitted row beyond A rows");

	a_load_after_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cell_load |=> state_q == mae_pkg::ST_DRAIN)
		else $error("chain load without drain");

endmodule
